### rtl/tcw_pkg.sv
// Shared types and constants for the text console writer.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package tcw_pkg;

   localparam int COLUMNS_DEFAULT = 80;
   localparam int ROWS_DEFAULT    = 25;
   localparam int QUEUE_DEPTH     = 2;

   localparam int FUNC_W  = 2;
   localparam int CHAR_W  = 8;
   localparam int ADDR_W  = 11;
   localparam int POS_W   = 11;
   localparam int COL_OUT_W  = 7;
   localparam int LINE_OUT_W = 5;
   localparam int CELL_W  = 16;
   localparam int COLOR_W = 8;

   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 40;

   localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

   localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = 8'h08;
   localparam logic [CHAR_W-1:0] CHAR_TAB       = 8'h09;
   localparam logic [CHAR_W-1:0] CHAR_NEWLINE   = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_RETURN    = 8'h0D;
   localparam logic [CHAR_W-1:0] CHAR_BLANK     = 8'h20;

   localparam int TAB_STEP = 8;
   localparam logic [COLOR_W-1:0] RESET_COLOR = 8'h07;

   localparam logic [2:0] OP_PRINT     = 3'd0;
   localparam logic [2:0] OP_NEWLINE   = 3'd1;
   localparam logic [2:0] OP_RETURN    = 3'd2;
   localparam logic [2:0] OP_TAB       = 3'd3;
   localparam logic [2:0] OP_BACKSPACE = 3'd4;
   localparam logic [2:0] OP_CLEAR     = 3'd5;
   localparam logic [2:0] OP_READ      = 3'd6;
   localparam logic [2:0] OP_NOP       = 3'd7;

   typedef struct packed {
      logic [2:0]        op;
      logic [CHAR_W-1:0] char_code;
      logic [ADDR_W-1:0] cell_address;
      logic              addr_ok;
   } cmd_type;

endpackage

### rtl/text_console_writer.sv
// Text console writer: a character grid with cursor, fed by request transactions.
// A front end classifies requests, a queue decouples it from the execution engine.
// Depends on tcw_pkg, tcw_front, tcw_queue and tcw_engine.
//
// Each request transaction carries a function in req_tuser (put character,
// clear screen, read one cell), and a character and cell address in req_tdata.
// Every request yields exactly one response transaction with the cursor
// position, column and line after the request, and the cell for a read.
// The attribute byte for written and blanked cells is set through csr_we and
// csr_wdata, by the user only while the block is idle; the block does not check.
// An ordinary put, read or no-op holds the execution engine while it takes the
// command, executes it, responds, and waits while the response register empties,
// so the engine takes no new request before it is through with the last one.
// A clear and a put that runs past the bottom line add a sweep over every cell
// of the grid for the clear or the scroll, made through the single write port
// of the cell memory. After reset the engine fills the grid with blank cells;
// requests are queued meanwhile and run afterwards.
// When the receiver holds rsp_tready low, the response waits in its register,
// the engine stops taking commands and the queue and front end fill up before
// req_tready drops.
`timescale 1ns / 1ps

module text_console_writer #(
   parameter int COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
   parameter int ROWS    = tcw_pkg::ROWS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // char_code[7:0], cell_address[18:8], zero[23:19]
   input  logic [tcw_pkg::REQ_DATA_W-1:0]  req_tdata,
   // func[1:0]
   input  logic [tcw_pkg::FUNC_W-1:0]      req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // cursor_pos[10:0], cursor_column[17:11], cursor_line[22:18],
   // cell_value[38:23], zero[39]
   output logic [tcw_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                            csr_we,
   input  logic [tcw_pkg::COLOR_W-1:0]     csr_wdata
);
   import tcw_pkg::*;

   logic    push_valid, push_ready;
   cmd_type push_cmd;
   logic    pop_valid, pop;
   cmd_type pop_cmd;

   tcw_front #(
      .CELLS (COLUMNS * ROWS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd)
   );

   tcw_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_cmd    (pop_cmd)
   );

   tcw_engine #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (pop_valid),
      .cmd_pop    (pop),
      .cmd        (pop_cmd),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

### rtl/tcw_front.sv
// Front end of the text console writer: accepts request transactions,
// classifies them into commands and hands them to the command queue.
// Depends on tcw_pkg.
`timescale 1ns / 1ps

module tcw_front #(
   parameter int CELLS = tcw_pkg::COLUMNS_DEFAULT * tcw_pkg::ROWS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [tcw_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic [tcw_pkg::FUNC_W-1:0]      req_tuser,
   output logic                            push_valid,
   input  logic                            push_ready,
   output tcw_pkg::cmd_type                push_cmd
);
   import tcw_pkg::*;

   logic    hold_valid_ff, hold_valid_in;
   cmd_type hold_cmd_ff, hold_cmd_in;
   cmd_type decoded;
   logic    accept;

   always_comb begin
      decoded.char_code    = req_tdata[CHAR_W-1:0];
      decoded.cell_address = req_tdata[CHAR_W+ADDR_W-1:CHAR_W];
      decoded.addr_ok      = (32'(decoded.cell_address) < CELLS);
      case (req_tuser)
         FUNC_PUT: begin
            case (decoded.char_code)
               CHAR_NEWLINE:   decoded.op = OP_NEWLINE;
               CHAR_RETURN:    decoded.op = OP_RETURN;
               CHAR_TAB:       decoded.op = OP_TAB;
               CHAR_BACKSPACE: decoded.op = OP_BACKSPACE;
               default:        decoded.op = OP_PRINT;
            endcase
         end
         FUNC_CLEAR: decoded.op = OP_CLEAR;
         FUNC_READ:  decoded.op = OP_READ;
         default:    decoded.op = OP_NOP;
      endcase
   end

   assign req_tready = !hold_valid_ff || push_ready;
   assign accept     = req_tvalid && req_tready;
   assign push_valid = hold_valid_ff;
   assign push_cmd   = hold_cmd_ff;

   always_comb begin
      hold_valid_in = hold_valid_ff && !push_ready;
      hold_cmd_in   = hold_cmd_ff;
      if (accept) begin
         hold_valid_in = 1'b1;
         hold_cmd_in   = decoded;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
      hold_cmd_ff <= hold_cmd_in;
   end

endmodule

### rtl/tcw_queue.sv
// Short command queue between the front end and the execution engine.
// Depends on tcw_pkg for the command type and depth.
`timescale 1ns / 1ps

module tcw_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  tcw_pkg::cmd_type push_cmd,
   output logic             pop_valid,
   input  logic             pop,
   output tcw_pkg::cmd_type pop_cmd
);
   import tcw_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type            slots_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign push_ready = (32'(count_ff) < QUEUE_DEPTH);
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = slots_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (32'(wr_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (32'(rd_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

### rtl/tcw_engine.sv
// Execution engine of the text console writer: cell memory, cursor,
// scroll and clear sweeps, color register and the response register.
// Depends on tcw_pkg.
`timescale 1ns / 1ps

module tcw_engine #(
   parameter int COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
   parameter int ROWS    = tcw_pkg::ROWS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            cmd_valid,
   output logic                            cmd_pop,
   input  tcw_pkg::cmd_type                cmd,
   input  logic                            csr_we,
   input  logic [tcw_pkg::COLOR_W-1:0]     csr_wdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [tcw_pkg::RSP_DATA_W-1:0]  rsp_tdata
);
   import tcw_pkg::*;

   localparam int CELLS  = COLUMNS * ROWS;
   localparam int MOVE   = CELLS - COLUMNS;
   localparam int MEM_AW = $clog2(CELLS);
   localparam int BASE_W = $clog2(CELLS + 1);
   localparam int COL_W  = $clog2(COLUMNS + TAB_STEP);
   localparam int ROW_W  = $clog2(ROWS + 1);
   localparam logic [BASE_W-1:0] LAST_BASE = BASE_W'(MOVE);

   localparam logic [2:0] S_INIT   = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_EXEC   = 3'd2;
   localparam logic [2:0] S_CLEAR  = 3'd3;
   localparam logic [2:0] S_SCROLL = 3'd4;
   localparam logic [2:0] S_DONE   = 3'd5;

   logic [CELL_W-1:0]     cells_mem [CELLS];

   logic [2:0]            state_ff, state_in;
   cmd_type               cmd_ff, cmd_in;
   logic [COL_W-1:0]      col_ff, col_in;
   logic [ROW_W-1:0]      row_ff, row_in;
   logic [BASE_W-1:0]     base_ff, base_in;
   logic [MEM_AW-1:0]     cnt_ff, cnt_in;
   logic                  wr_en_ff, wr_en_in;
   logic                  wr_copy_ff, wr_copy_in;
   logic [MEM_AW-1:0]     wr_addr_ff, wr_addr_in;
   logic [CELL_W-1:0]     wr_data_ff, wr_data_in;
   logic [CELL_W-1:0]     rd_data_ff;
   logic [MEM_AW-1:0]     rd_addr;
   logic [COLOR_W-1:0]    color_ff;
   logic                  out_valid_ff, out_valid_in;
   logic [RSP_DATA_W-1:0] out_data_ff, out_data_in;

   logic [CELL_W-1:0]     blank;
   logic [31:0]           here_sum;
   logic [31:0]           pos_sum;
   logic [CELL_W-1:0]     value;
   logic                  last_cnt;

   assign blank      = {color_ff, CHAR_BLANK};
   assign here_sum   = 32'(base_ff) + 32'(col_ff);
   assign pos_sum    = here_sum;
   assign last_cnt   = (32'(cnt_ff) == CELLS - 1);
   assign cmd_pop    = (state_ff == S_IDLE) && cmd_valid && !out_valid_ff;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   always_comb begin
      if (state_ff == S_SCROLL) begin
         rd_addr = (32'(cnt_ff) < MOVE) ? MEM_AW'(32'(cnt_ff) + COLUMNS) : '0;
      end else begin
         rd_addr = cmd_ff.addr_ok ? MEM_AW'(cmd_ff.cell_address) : '0;
      end
   end

   always_comb begin
      value = (cmd_ff.op == OP_READ && cmd_ff.addr_ok) ? rd_data_ff : '0;
   end

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      base_in      = base_ff;
      cnt_in       = cnt_ff;
      wr_en_in     = 1'b0;
      wr_copy_in   = 1'b0;
      wr_addr_in   = wr_addr_ff;
      wr_data_in   = wr_data_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_data_in  = out_data_ff;

      case (state_ff)
         S_INIT: begin
            wr_en_in   = 1'b1;
            wr_addr_in = cnt_ff;
            wr_data_in = {RESET_COLOR, CHAR_BLANK};
            cnt_in     = cnt_ff + 1'b1;
            if (last_cnt) begin
               cnt_in   = '0;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (cmd_pop) begin
               cmd_in   = cmd;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_DONE;
            case (cmd_ff.op)
               OP_PRINT: begin
                  wr_en_in   = 1'b1;
                  wr_addr_in = MEM_AW'(here_sum);
                  wr_data_in = {color_ff, cmd_ff.char_code};
                  col_in     = col_ff + 1'b1;
               end
               OP_NEWLINE: begin
                  col_in  = '0;
                  row_in  = row_ff + 1'b1;
                  base_in = BASE_W'(32'(base_ff) + COLUMNS);
               end
               OP_RETURN: begin
                  col_in = '0;
               end
               OP_TAB: begin
                  col_in = COL_W'(32'(col_ff) + TAB_STEP) & ~COL_W'(TAB_STEP - 1);
               end
               OP_BACKSPACE: begin
                  if (col_ff != '0) begin
                     col_in     = col_ff - 1'b1;
                     wr_en_in   = 1'b1;
                     wr_addr_in = MEM_AW'(here_sum - 32'd1);
                     wr_data_in = blank;
                  end
               end
               OP_CLEAR: begin
                  col_in   = '0;
                  row_in   = '0;
                  base_in  = '0;
                  cnt_in   = '0;
                  state_in = S_CLEAR;
               end
               default: begin
               end
            endcase
            if (32'(col_in) >= COLUMNS) begin
               col_in  = '0;
               row_in  = row_in + 1'b1;
               base_in = BASE_W'(32'(base_in) + COLUMNS);
            end
            if (32'(row_in) >= ROWS) begin
               row_in   = ROW_W'(ROWS - 1);
               base_in  = LAST_BASE;
               cnt_in   = '0;
               state_in = S_SCROLL;
            end
         end
         S_CLEAR: begin
            wr_en_in   = 1'b1;
            wr_addr_in = cnt_ff;
            wr_data_in = blank;
            cnt_in     = cnt_ff + 1'b1;
            if (last_cnt) begin
               cnt_in   = '0;
               state_in = S_DONE;
            end
         end
         S_SCROLL: begin
            wr_en_in   = 1'b1;
            wr_addr_in = cnt_ff;
            wr_copy_in = (32'(cnt_ff) < MOVE);
            wr_data_in = blank;
            cnt_in     = cnt_ff + 1'b1;
            if (last_cnt) begin
               cnt_in   = '0;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            out_valid_in = 1'b1;
            out_data_in  = {1'b0, value, LINE_OUT_W'(row_ff), COL_OUT_W'(col_ff),
                            pos_sum[POS_W-1:0]};
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         col_ff       <= '0;
         row_ff       <= '0;
         base_ff      <= '0;
         cnt_ff       <= '0;
         wr_en_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
         color_ff     <= RESET_COLOR;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         base_ff      <= base_in;
         cnt_ff       <= cnt_in;
         wr_en_ff     <= wr_en_in;
         out_valid_ff <= out_valid_in;
         if (csr_we) begin
            color_ff <= csr_wdata;
         end
      end
      cmd_ff      <= cmd_in;
      wr_copy_ff  <= wr_copy_in;
      wr_addr_ff  <= wr_addr_in;
      wr_data_ff  <= wr_data_in;
      out_data_ff <= out_data_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en_ff) begin
         cells_mem[wr_addr_ff] <= wr_copy_ff ? rd_data_ff : wr_data_ff;
      end
      rd_data_ff <= cells_mem[rd_addr];
   end

endmodule
